/* sv/hcbd_pkg.sv */
// Shared types, constants and helpers for the HTTP chunked body decoder.
// No dependencies; the parser, the result register and the top level import this package.
`default_nettype none

package hcbd_pkg;

  // Default widths of the chunk size accumulator and the payload counter
  localparam int SIZE_BITS_DEF   = 31;
  localparam int COUNT_BITS_DEF  = 32;
  localparam int BYTE_W          = 8;
  localparam int PAYLOAD_COUNT_W = 32;

  // Characters of interest on a chunk size line
  localparam logic [BYTE_W-1:0] CHAR_CR   = 8'h0D;
  localparam logic [BYTE_W-1:0] CHAR_LF   = 8'h0A;
  localparam logic [BYTE_W-1:0] CHAR_SEMI = 8'h3B;

  // One input item
  typedef struct packed {
    logic [BYTE_W-1:0] in_byte;
    logic              new_message;
    logic              ends_segment;
  } item_t;

  // One result item
  typedef struct packed {
    logic [BYTE_W-1:0]          body_byte;
    logic                       is_payload;
    logic                       stream_finished;
    logic [PAYLOAD_COUNT_W-1:0] payload_count;
    logic                       segment_closed;
  } result_t;

  // Decode an ASCII hex digit: bit 4 flags a digit, bits 3:0 hold its value
  function automatic logic [4:0] hex_digit(input logic [BYTE_W-1:0] c);
    logic [4:0] r;
    r = 5'b0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h57)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h37)};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

/* sv/hcbd_ifs.sv */
// Valid/ready channel interfaces for the body decoder input and result items.
// Plain logic fields; no package dependency.
`default_nettype none

interface hcbd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       new_message;
  logic       ends_segment;

  modport source (output valid, output in_byte, output new_message,
                  output ends_segment, input ready);
  modport sink   (input valid, input in_byte, input new_message,
                  input ends_segment, output ready);
endinterface

interface hcbd_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  body_byte;
  logic        is_payload;
  logic        stream_finished;
  logic [31:0] payload_count;
  logic        segment_closed;

  modport source (output valid, output body_byte, output is_payload,
                  output stream_finished, output payload_count,
                  output segment_closed, input ready);
  modport sink   (input valid, input body_byte, input is_payload,
                  input stream_finished, input payload_count,
                  input segment_closed, output ready);
endinterface

`default_nettype wire

/* sv/hcbd_parser.sv */
// Chunk parser: phase, size accumulator, extension flag and payload counter,
// plus the combinational result for the item in the input register. Uses hcbd_pkg.
`default_nettype none

module hcbd_parser #(
  parameter int SIZE_BITS  = hcbd_pkg::SIZE_BITS_DEF,
  parameter int COUNT_BITS = hcbd_pkg::COUNT_BITS_DEF
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            advance,
  input  wire logic            chunked_mode,
  input  wire hcbd_pkg::item_t item,
  output hcbd_pkg::result_t    result
);
  import hcbd_pkg::*;

  typedef enum logic [1:0] {
    PH_SIZE  = 2'd0,
    PH_DATA  = 2'd1,
    PH_AFTER = 2'd2,
    PH_DONE  = 2'd3
  } phase_t;

  phase_t                phase, phase_next;
  logic [SIZE_BITS-1:0]  bytes_left, bytes_left_next;
  logic                  in_extension, in_extension_next;
  logic [COUNT_BITS-1:0] delivered_total, delivered_total_next;

  // Work out the next parser state and the result for the held item
  always_comb begin
    logic [4:0] hv;
    logic       payload;
    hv                   = hex_digit(item.in_byte);
    payload              = 1'b0;
    phase_next           = item.new_message ? PH_SIZE : phase;
    bytes_left_next      = item.new_message ? '0 : bytes_left;
    in_extension_next    = item.new_message ? 1'b0 : in_extension;
    delivered_total_next = item.new_message ? '0 : delivered_total;

    if (!chunked_mode) begin
      payload = 1'b1;
    end else begin
      // Treat an exhausted data phase as after-data
      if (phase_next == PH_DATA && bytes_left_next == '0) begin
        phase_next = PH_AFTER;
      end
      unique case (phase_next)
        PH_SIZE: begin
          if (item.in_byte == CHAR_LF) begin
            phase_next        = (bytes_left_next == '0) ? PH_DONE : PH_DATA;
            in_extension_next = 1'b0;
          end else if (item.in_byte == CHAR_SEMI) begin
            in_extension_next = 1'b1;
          end else if (item.in_byte != CHAR_CR && !in_extension_next && hv[4]) begin
            // Saturate once the top nibble would shift out
            if (|bytes_left_next[SIZE_BITS-1 -: 4]) begin
              bytes_left_next = '1;
            end else begin
              bytes_left_next = {bytes_left_next[SIZE_BITS-5:0], hv[3:0]};
            end
          end
        end
        PH_DATA: begin
          payload         = 1'b1;
          bytes_left_next = bytes_left_next - SIZE_BITS'(1);
          if (bytes_left_next == '0) begin
            phase_next = PH_AFTER;
          end
        end
        PH_AFTER: begin
          if (item.in_byte == CHAR_LF) begin
            phase_next        = PH_SIZE;
            bytes_left_next   = '0;
            in_extension_next = 1'b0;
          end
        end
        PH_DONE: begin
          // Drop everything after the final chunk
        end
        default: begin
          phase_next = PH_SIZE;
        end
      endcase
    end

    if (payload) begin
      delivered_total_next = delivered_total_next + COUNT_BITS'(1);
    end

    result.body_byte       = item.in_byte;
    result.is_payload      = payload;
    result.stream_finished = (phase_next == PH_DONE);
    result.payload_count   = PAYLOAD_COUNT_W'(delivered_total_next);
    result.segment_closed  = item.ends_segment;
  end

  // Hold parser state; advance when the held item moves to the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_SIZE;
      bytes_left      <= '0;
      in_extension    <= 1'b0;
      delivered_total <= '0;
    end else if (advance) begin
      phase           <= phase_next;
      bytes_left      <= bytes_left_next;
      in_extension    <= in_extension_next;
      delivered_total <= delivered_total_next;
    end
  end

endmodule

`default_nettype wire

/* sv/hcbd_out_reg.sv */
// Result register of the body decoder, driving the output channel.
// Uses hcbd_pkg and hcbd_out_if.
`default_nettype none

module hcbd_out_reg (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              load,
  input  wire hcbd_pkg::result_t result,
  output logic                   can_load,
  hcbd_out_if.source             tx
);
  import hcbd_pkg::*;

  logic    out_valid;
  result_t out_data;

  // Free when empty or when the held item leaves this cycle
  assign can_load = !out_valid || tx.ready;

  // Hold the result until taken, load a new one when free
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (tx.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data <= result;
    end
  end

  assign tx.valid           = out_valid;
  assign tx.body_byte       = out_data.body_byte;
  assign tx.is_payload      = out_data.is_payload;
  assign tx.stream_finished = out_data.stream_finished;
  assign tx.payload_count   = out_data.payload_count;
  assign tx.segment_closed  = out_data.segment_closed;

endmodule

`default_nettype wire

/* sv/http_chunked_body_decoder_unit.sv */
// HTTP chunked body decoder, top level.
// Depends on hcbd_pkg, hcbd_ifs, hcbd_parser and hcbd_out_reg.
//
// Usage:
//   body_in carries one body byte per item with new_message (first byte of a
//   body, clears parser and count) and ends_segment. body_out returns one
//   result item per input item, in order: the byte, whether it is payload,
//   the finished flag, the running payload count and the segment mark.
//   chunked_mode is written via cfg_write_en/cfg_write_data, by the user only
//   while idle (not enforced); 0 passes all as payload, 1 decodes chunked.
// Timing:
//   An accepted item is held in the input register; when the result register
//   is free its result is loaded there and offered on body_out until taken.
//   One item per cycle is sustained while body_out.ready stays high; the rate
//   is set by the combinational parser update between the two registers.
// Reset clears both registers' valid flags, the parser state, the count and
// chunked_mode. When the receiver stalls, the result register holds its item;
// the input register still takes one more item, then body_in.ready drops.
`default_nettype none

module http_chunked_body_decoder_unit #(
  parameter int SIZE_BITS  = hcbd_pkg::SIZE_BITS_DEF,
  parameter int COUNT_BITS = hcbd_pkg::COUNT_BITS_DEF
) (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   cfg_write_en,
  input  wire logic   cfg_write_data,
  hcbd_in_if.sink     body_in,
  hcbd_out_if.source  body_out
);
  import hcbd_pkg::*;

  logic    chunked_mode;
  logic    in_valid;
  item_t   in_data;
  logic    can_load;
  logic    advance;
  result_t result;

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      chunked_mode <= 1'b0;
    end else if (cfg_write_en) begin
      chunked_mode <= cfg_write_data;
    end
  end

  // Move the held item on when the result register is free
  assign advance       = in_valid && can_load;
  assign body_in.ready = !in_valid || can_load;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (body_in.ready) begin
      in_valid <= body_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (body_in.valid && body_in.ready) begin
      in_data.in_byte      <= body_in.in_byte;
      in_data.new_message  <= body_in.new_message;
      in_data.ends_segment <= body_in.ends_segment;
    end
  end

  hcbd_parser #(
    .SIZE_BITS  (SIZE_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_parser (
    .clk          (clk),
    .rst          (rst),
    .advance      (advance),
    .chunked_mode (chunked_mode),
    .item         (in_data),
    .result       (result)
  );

  hcbd_out_reg u_out_reg (
    .clk      (clk),
    .rst      (rst),
    .load     (advance),
    .result   (result),
    .can_load (can_load),
    .tx       (body_out)
  );

  // A held item with a stalled result register blocks the input
  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    in_valid && body_out.valid && !body_out.ready |-> !body_in.ready)
    else $error("input accepted while both registers are full");

  // An accepted item is held in the input register next cycle
  a_accept_held: assert property (@(posedge clk) disable iff (rst)
    body_in.valid && body_in.ready |=> in_valid)
    else $error("accepted item lost");

  // A held item moving on always yields a result next cycle
  a_advance_result: assert property (@(posedge clk) disable iff (rst)
    advance |=> body_out.valid)
    else $error("result missing after advance");

endmodule

`default_nettype wire
